// File: hdl/ipv4_udp_frame_classifier_macros.svh
// Assertion macros shared by the frame classifier RTL.
`ifndef IPV4_UDP_FRAME_CLASSIFIER_MACROS_SVH
`define IPV4_UDP_FRAME_CLASSIFIER_MACROS_SVH

// Antecedent implies consequent in the same cycle; uses clk and arst_n in scope.
`define IPUC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition must never hold at a clock edge outside reset.
`define IPUC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// File: hdl/ipuc_pkg.sv
// Types and constants of the frame classifier.
package ipuc_pkg;

	// Protocol constants
	localparam logic [15:0] ETH_ARP    = 16'h0806;
	localparam logic [15:0] ETH_IPV4   = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP = 8'h01;
	localparam logic [7:0]  PROTO_UDP  = 8'h11;
	localparam logic [15:0] FRAG_MASK  = 16'h3FFF;

	localparam int unsigned ETH_HDR_LEN = 14;
	localparam int unsigned UDP_HDR_LEN = 8;

	// Minimum received lengths for each group of header fields
	localparam int unsigned MIN_ETH_LEN  = 14;
	localparam int unsigned MIN_IP_LEN   = 24;
	localparam int unsigned MIN_ADDR_LEN = 34;

	// Byte positions of captured fields
	localparam int unsigned POS_ETYPE    = 12;
	localparam int unsigned POS_IHL      = 14;
	localparam int unsigned POS_TOTLEN   = 16;
	localparam int unsigned POS_FRAG     = 20;
	localparam int unsigned POS_PROTO    = 23;
	localparam int unsigned POS_SRC      = 26;
	localparam int unsigned POS_DST      = 30;

	// Register map
	localparam int unsigned ADDR_SLOTS = 4;
	localparam logic [2:0] REG_TABLE_USED    = 3'd4;
	localparam logic [2:0] REG_PAYLOAD_LIMIT = 3'd5;

	localparam logic [31:0] TABLE_RESET [ADDR_SLOTS] = '{
		32'h0A00_000A, 32'h0A00_0014, 32'h0000_0000, 32'h0000_0000
	};
	localparam logic [2:0]  TABLE_USED_RESET    = 3'd2;
	localparam logic [10:0] PAYLOAD_LIMIT_RESET = 11'd512;

	// Frames held between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		VERDICT_DROP    = 2'd0,
		VERDICT_FORWARD = 2'd1,
		VERDICT_ENCRYPT = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		CAUSE_NONE      = 3'd0,
		CAUSE_ETHERTYPE = 3'd1,
		CAUSE_PROTO     = 3'd2,
		CAUSE_SIZE      = 3'd3,
		CAUSE_SRC       = 3'd4,
		CAUSE_DST       = 3'd5,
		CAUSE_TRUNC     = 3'd6
	} cause_t;

	// Header fields captured by the front end
	typedef struct packed {
		logic [15:0] ether_kind;
		logic [15:0] total_len;
		logic [15:0] flags_frag;
		logic [7:0]  proto;
		logic [3:0]  hdr_words;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
	} hdr_t;

	// One classification result
	typedef struct packed {
		logic [10:0] frame_length;
		logic [6:0]  payload_offset;
		logic [1:0]  key_index;
		cause_t      drop_cause;
		verdict_t    verdict;
	} res_t;

endpackage

// File: hdl/ipuc_fifo.sv
// Small frame-record queue between the parser and the decision pipeline.
module ipuc_fifo #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head_data,
	output logic         full,
	output logic         empty
);
	import ipuc_pkg::*;

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);

	logic [W-1:0]  mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full      = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign head_data = mem_q[rd_ptr_q];

	// storage, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/ipuc_front.sv
// Byte parser: counts frame bytes and captures the header fields.
module ipuc_front #(
	parameter int unsigned CW        = 11,
	parameter int unsigned COUNT_MAX = 2047
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	input  logic            queue_full,
	output logic            push,
	output logic [CW-1:0]   push_rx,
	output ipuc_pkg::hdr_t  push_hdr
);
	import ipuc_pkg::*;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_n;
	hdr_t          hdr_q;
	hdr_t          hdr_n;
	logic          accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && in_last;
	assign push_rx  = cnt_n;
	assign push_hdr = hdr_n;

	// saturating byte count
	assign cnt_n = (cnt_q < CW'(COUNT_MAX)) ? cnt_q + 1'b1 : cnt_q;

	// field capture at fixed byte positions
	always_comb begin
		hdr_n = hdr_q;
		if (cnt_q == CW'(POS_ETYPE) || cnt_q == CW'(POS_ETYPE + 1)) begin
			hdr_n.ether_kind = {hdr_q.ether_kind[7:0], in_byte};
		end else if (cnt_q == CW'(POS_IHL)) begin
			hdr_n.hdr_words = in_byte[3:0];
		end else if (cnt_q == CW'(POS_TOTLEN) || cnt_q == CW'(POS_TOTLEN + 1)) begin
			hdr_n.total_len = {hdr_q.total_len[7:0], in_byte};
		end else if (cnt_q == CW'(POS_FRAG) || cnt_q == CW'(POS_FRAG + 1)) begin
			hdr_n.flags_frag = {hdr_q.flags_frag[7:0], in_byte};
		end else if (cnt_q == CW'(POS_PROTO)) begin
			hdr_n.proto = in_byte;
		end else if (cnt_q >= CW'(POS_SRC) && cnt_q <= CW'(POS_SRC + 3)) begin
			hdr_n.src_addr = {hdr_q.src_addr[23:0], in_byte};
		end else if (cnt_q >= CW'(POS_DST) && cnt_q <= CW'(POS_DST + 3)) begin
			hdr_n.dst_addr = {hdr_q.dst_addr[23:0], in_byte};
		end
	end

	// frame state; cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			hdr_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				cnt_q <= '0;
				hdr_q <= '0;
			end else begin
				cnt_q <= cnt_n;
				hdr_q <= hdr_n;
			end
		end
	end

endmodule

// File: hdl/ipuc_back.sv
// Decision pipeline: length trim and table lookup, then verdict and output register.
module ipuc_back #(
	parameter int unsigned CW    = 11,
	parameter int unsigned SLOTS = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  logic [CW-1:0]           head_rx,
	input  ipuc_pkg::hdr_t          head_hdr,
	output logic                    pop,
	input  logic [SLOTS-1:0][31:0]  table_addr,
	input  logic [2:0]              table_used,
	input  logic [10:0]             payload_limit,
	output logic                    res_valid,
	input  logic                    res_ready,
	output ipuc_pkg::res_t          res
);
	import ipuc_pkg::*;

	// stage 1 comb
	logic [16:0]   trim_c;
	logic [CW-1:0] len_c;
	logic [6:0]    off_c;
	logic          src_ok_c;
	logic          dst_ok_c;
	logic [1:0]    key_c;

	// stage 1 registers
	logic          valid_s1;
	logic [CW-1:0] rx_s1;
	logic [CW-1:0] len_s1;
	logic [6:0]    off_s1;
	logic          short_eth_s1;
	logic          short_ip_s1;
	logic          short_addr_s1;
	logic          is_arp_s1;
	logic          is_ipv4_s1;
	logic          is_icmp_s1;
	logic          udp_whole_s1;
	logic          src_ok_s1;
	logic          dst_ok_s1;
	logic [1:0]    key_s1;

	// stage 2 comb
	logic [CW-1:0] off_ext;
	logic [CW-1:0] diff_c;
	logic          size_bad_c;
	res_t          res_c;

	logic          out_valid_q;
	res_t          res_q;
	logic          adv_s1;

	assign adv_s1    = !out_valid_q || res_ready;
	assign pop       = head_valid && (!valid_s1 || adv_s1);
	assign res_valid = out_valid_q;
	assign res       = res_q;

	// length trim and payload offset
	assign trim_c = 17'(head_hdr.total_len) + 17'(ETH_HDR_LEN);
	assign len_c  = (trim_c < 17'(head_rx)) ? CW'(trim_c) : head_rx;
	assign off_c  = 7'({head_hdr.hdr_words, 2'b00}) + 7'(ETH_HDR_LEN + UDP_HDR_LEN);

	// address table compare; lowest matching entry wins
	always_comb begin
		src_ok_c = 1'b0;
		dst_ok_c = 1'b0;
		key_c    = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (3'(i) < table_used) begin
				if (table_addr[i] == head_hdr.src_addr) begin
					src_ok_c = 1'b1;
					key_c    = 2'(i);
				end
				if (table_addr[i] == head_hdr.dst_addr) begin
					dst_ok_c = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s1) begin
			valid_s1 <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rx_s1         <= head_rx;
			len_s1        <= len_c;
			off_s1        <= off_c;
			short_eth_s1  <= head_rx < CW'(MIN_ETH_LEN);
			short_ip_s1   <= head_rx < CW'(MIN_IP_LEN);
			short_addr_s1 <= head_rx < CW'(MIN_ADDR_LEN);
			is_arp_s1     <= head_hdr.ether_kind == ETH_ARP;
			is_ipv4_s1    <= head_hdr.ether_kind == ETH_IPV4;
			is_icmp_s1    <= head_hdr.proto == PROTO_ICMP;
			udp_whole_s1  <= (head_hdr.proto == PROTO_UDP) &&
			                 ((head_hdr.flags_frag & FRAG_MASK) == '0);
			src_ok_s1     <= src_ok_c;
			dst_ok_s1     <= dst_ok_c;
			key_s1        <= key_c;
		end
	end

	// payload size test
	assign off_ext    = CW'(off_s1);
	assign diff_c     = len_s1 - off_ext;
	assign size_bad_c = (off_ext >= len_s1) || (17'(diff_c) > 17'(payload_limit));

	// verdict in check order
	always_comb begin
		res_c = '0;
		res_c.verdict    = VERDICT_DROP;
		res_c.drop_cause = CAUSE_NONE;
		if (short_eth_s1) begin
			res_c.drop_cause = CAUSE_TRUNC;
		end else if (is_arp_s1) begin
			res_c.verdict      = VERDICT_FORWARD;
			res_c.frame_length = 11'(rx_s1);
		end else if (!is_ipv4_s1) begin
			res_c.drop_cause = CAUSE_ETHERTYPE;
		end else if (short_ip_s1) begin
			res_c.drop_cause = CAUSE_TRUNC;
		end else if (is_icmp_s1) begin
			res_c.verdict      = VERDICT_FORWARD;
			res_c.frame_length = 11'(len_s1);
		end else if (!udp_whole_s1) begin
			res_c.drop_cause = CAUSE_PROTO;
		end else if (size_bad_c) begin
			res_c.drop_cause = CAUSE_SIZE;
		end else if (short_addr_s1) begin
			res_c.drop_cause = CAUSE_TRUNC;
		end else if (!src_ok_s1) begin
			res_c.drop_cause = CAUSE_SRC;
		end else if (!dst_ok_s1) begin
			res_c.drop_cause = CAUSE_DST;
		end else begin
			res_c.verdict        = VERDICT_ENCRYPT;
			res_c.key_index      = key_s1;
			res_c.payload_offset = off_s1;
			res_c.frame_length   = 11'(len_s1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			res_q <= res_c;
		end
	end

endmodule

// File: hdl/ipv4_udp_frame_classifier.sv
// Ethernet IPv4/UDP frame classifier: top level with configuration registers.
// Throughput: one frame byte per cycle while the queue is not full; one result per cycle at most.
// After the final byte is taken, the frame passes through the queue, the stage 1 registers and the output register.
// A four-frame queue between parser and decision absorbs output stalls; input stalls when full.
// Reset (arst_n low) clears byte count, fields, queue and pipeline valids, and loads
// the address table, entry count and payload limit defaults.
`include "ipv4_udp_frame_classifier_macros.svh"

module ipv4_udp_frame_classifier #(
	parameter int unsigned TABLE_ENTRIES = 4,
	parameter int unsigned COUNT_MAX     = 2047
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] frame_byte
	input  logic        s_tlast,   // frame_end
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [1:0] verdict, [4:2] drop_cause, [6:5] key_index,
	                               // [13:7] payload_offset, [24:14] frame_length
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import ipuc_pkg::*;

	localparam int unsigned CW    = $clog2(COUNT_MAX + 1);
	localparam int unsigned SLOTS = (TABLE_ENTRIES < ADDR_SLOTS) ? TABLE_ENTRIES : ADDR_SLOTS;
	localparam int unsigned QW    = CW + $bits(hdr_t);

	logic [SLOTS-1:0][31:0] table_q;
	logic [2:0]             used_q;
	logic [10:0]            limit_q;

	logic          push;
	logic [CW-1:0] push_rx;
	hdr_t          push_hdr;
	logic          pop;
	logic [QW-1:0] head_data;
	logic          fifo_full;
	logic          fifo_empty;
	res_t          res;

	assign cfg_ready = 1'b1;

	// configuration registers; indices past the map are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				table_q[i] <= TABLE_RESET[i];
			end
			used_q  <= TABLE_USED_RESET;
			limit_q <= PAYLOAD_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (cfg_index == 3'(i)) begin
					table_q[i] <= cfg_data;
				end
			end
			if (cfg_index == REG_TABLE_USED) begin
				used_q <= cfg_data[2:0];
			end
			if (cfg_index == REG_PAYLOAD_LIMIT) begin
				limit_q <= cfg_data[10:0];
			end
		end
	end

	ipuc_front #(
		.CW        (CW),
		.COUNT_MAX (COUNT_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.queue_full (fifo_full),
		.push       (push),
		.push_rx    (push_rx),
		.push_hdr   (push_hdr)
	);

	ipuc_fifo #(
		.W (QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_rx, push_hdr}),
		.pop       (pop),
		.head_data (head_data),
		.full      (fifo_full),
		.empty     (fifo_empty)
	);

	ipuc_back #(
		.CW    (CW),
		.SLOTS (SLOTS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (!fifo_empty),
		.head_rx       (head_data[QW-1 -: CW]),
		.head_hdr      (head_data[$bits(hdr_t)-1:0]),
		.pop           (pop),
		.table_addr    (table_q),
		.table_used    (used_q),
		.payload_limit (limit_q),
		.res_valid     (m_tvalid),
		.res_ready     (m_tready),
		.res           (res)
	);

	assign m_tdata = {7'b0, res.frame_length, res.payload_offset, res.key_index,
	                  res.drop_cause, res.verdict};

	// checks
	`IPUC_ASSERT_NEVER(a_queue_overflow, push && fifo_full, "frame pushed into full queue")
	`IPUC_ASSERT_IMPLY(a_pass_no_cause, m_tvalid && res.verdict != VERDICT_DROP,
		res.drop_cause == CAUSE_NONE, "non-drop verdict carries a drop cause")
	`IPUC_ASSERT_IMPLY(a_drop_clean, m_tvalid && res.verdict == VERDICT_DROP,
		res.frame_length == '0 && res.key_index == '0 && res.payload_offset == '0,
		"dropped frame carries length, key or offset")

endmodule
